// ===== src/cmm_pkg.sv =====
// Shared types and constants for the confusion matrix metrics block.
// No dependencies; imported by the top level confusion_matrix_macro_metrics.
`default_nettype none
package cmm_pkg;

  localparam int FRAC_BITS        = 16;
  localparam int RATIO_W          = FRAC_BITS + 1;
  localparam int MAX_CLASSES_DEF  = 16;
  localparam int COUNT_BITS_DEF   = 32;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 12;

  localparam logic [CFG_IDX_W-1:0] CFG_CLASS_COUNT  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BETA_SQUARED = 1'd1;

  localparam logic [4:0]  CLASS_COUNT_RST  = 5'd2;
  localparam logic [11:0] BETA_SQUARED_RST = 12'd256;

  typedef struct packed {
    logic [3:0] true_class;
    logic [3:0] pred_class;
    logic       last;
  } cmm_in_t;

  typedef struct packed {
    logic [RATIO_W-1:0] accuracy;
    logic [RATIO_W-1:0] precision;
    logic [RATIO_W-1:0] recall;
    logic [RATIO_W-1:0] neg_pred_value;
    logic [RATIO_W-1:0] specificity;
    logic [RATIO_W-1:0] f_score;
    logic [31:0]        total_count;
    logic [31:0]        dropped_count;
  } cmm_out_t;

endpackage
`default_nettype wire

// ===== src/confusion_matrix_macro_metrics.sv =====
// Top level of the confusion matrix metrics block: accumulation, report sequencer.
// Depends on cmm_pkg, cmm_ram and cmm_div.
//
// An observation is taken when start is high and busy is low. A counted
// observation reads and writes back one matrix count in the RAM; a dropped one
// only bumps the drop counter. An observation flagged last also starts the
// report, which walks the matrix through the single RAM read port (3*K*K reads
// for K classes, K*K + 2*K in the binary case) and runs 4 divisions per class
// (one class in the binary case) plus 6 at the end on one shared divider.
// The report appears on out_data for one cycle with out_valid high and
// must be taken then; the matrix and drop counter are then clear.
`default_nettype none
module confusion_matrix_macro_metrics
  import cmm_pkg::*;
#(
  parameter int MAX_CLASSES = MAX_CLASSES_DEF,
  parameter int COUNT_BITS  = COUNT_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  output logic                       busy,
  input  wire cmm_in_t               in_data,
  output logic                       out_valid,
  output cmm_out_t                   out_data,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int CLS_W = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;
  localparam int IX_W  = (CLS_W > 4) ? CLS_W : 4;
  localparam int AW    = 2 * CLS_W;
  localparam int DEPTH = 1 << AW;
  localparam int KW    = $clog2(MAX_CLASSES + 1);
  localparam int SUM_W = COUNT_BITS + 2 * CLS_W;
  localparam int Q_W   = RATIO_W;
  localparam int S_W   = Q_W + CLS_W;
  localparam int M1_W  = 13 + Q_W;
  localparam int FD_W  = 13 + Q_W;
  localparam int FN_W  = 13 + 2 * Q_W;
  localparam int D_W   = (SUM_W > FD_W) ? SUM_W : FD_W;
  localparam int N_W   = ((SUM_W + FRAC_BITS) > FN_W) ? (SUM_W + FRAC_BITS) : FN_W;
  localparam int TX_W  = (SUM_W > 33) ? SUM_W : 33;
  localparam logic [Q_W-1:0] ONE_Q = {1'b1, {FRAC_BITS{1'b0}}};

  localparam logic [4:0] S_IDLE     = 5'd0;
  localparam logic [4:0] S_ACC      = 5'd1;
  localparam logic [4:0] S_TOT_RD   = 5'd2;
  localparam logic [4:0] S_TOT_AC   = 5'd3;
  localparam logic [4:0] S_ROW_RD   = 5'd4;
  localparam logic [4:0] S_ROW_AC   = 5'd5;
  localparam logic [4:0] S_COL_RD   = 5'd6;
  localparam logic [4:0] S_COL_AC   = 5'd7;
  localparam logic [4:0] S_CALC1    = 5'd8;
  localparam logic [4:0] S_CALC2    = 5'd9;
  localparam logic [4:0] S_CALC3    = 5'd10;
  localparam logic [4:0] S_DIV_GO   = 5'd11;
  localparam logic [4:0] S_DIV_WAIT = 5'd12;
  localparam logic [4:0] S_FMUL1    = 5'd13;
  localparam logic [4:0] S_FMUL2    = 5'd14;
  localparam logic [4:0] S_DONE     = 5'd15;

  localparam logic [3:0] SEL_PREC = 4'd0;
  localparam logic [3:0] SEL_REC  = 4'd1;
  localparam logic [3:0] SEL_NPV  = 4'd2;
  localparam logic [3:0] SEL_SPEC = 4'd3;
  localparam logic [3:0] SEL_MP   = 4'd4;
  localparam logic [3:0] SEL_MR   = 4'd5;
  localparam logic [3:0] SEL_MN   = 4'd6;
  localparam logic [3:0] SEL_MS   = 4'd7;
  localparam logic [3:0] SEL_ACC  = 4'd8;
  localparam logic [3:0] SEL_F    = 4'd9;

  logic [4:0]  state_r, state_nxt;
  logic [4:0]  class_count_r;
  logic [11:0] beta_r;
  logic [31:0] drop_r;
  logic        last_r;
  logic [AW-1:0] addr_r, rd_addr;
  logic        vld_r [DEPTH];

  logic [CLS_W-1:0] i_r, j_r, c_r, km1;
  logic [SUM_W-1:0] total_r, diag_r, row_r, col_r, tp_r;
  logic [SUM_W-1:0] fp_r, fn_r, t1_r, tn_r, dn_r, ds_r;
  logic [S_W-1:0]   sp_r, sr_r, sn_r, ss_r;
  logic [Q_W-1:0]   prec_r, rec_r, npv_r, spec_r, acc_r;
  logic [M1_W-1:0]  m1_r;
  logic [FD_W-1:0]  fden_r;
  logic [FN_W-1:0]  fnum_r;
  logic [3:0]       sel_r;

  logic [31:0]      cc32, k32;
  logic [KW-1:0]    k_eff;
  logic [D_W-1:0]   kdiv;
  logic [IX_W-1:0]  t_x, p_x;
  logic             accept, in_range;
  logic [COUNT_BITS-1:0] ram_rdata, cur, inc;
  logic [SUM_W-1:0] v;
  logic             div_go, div_done;
  logic [N_W-1:0]   div_num;
  logic [D_W-1:0]   div_den;
  logic [Q_W-1:0]   div_q;
  logic [TX_W-1:0]  total_x;
  logic             last_class;

  // effective class count: below 2 acts as 2, above MAX_CLASSES as MAX_CLASSES
  assign cc32  = 32'(class_count_r);
  assign k32   = (cc32 < 32'd2) ? 32'd2 :
                 ((cc32 > 32'(MAX_CLASSES)) ? 32'(MAX_CLASSES) : cc32);
  assign k_eff = KW'(k32);
  assign km1   = CLS_W'(k32 - 32'd1);
  assign kdiv  = (k_eff == KW'(2)) ? D_W'(1) : D_W'(k_eff);

  assign busy     = state_r != S_IDLE;
  assign accept   = start && !busy;
  assign t_x      = IX_W'(in_data.true_class);
  assign p_x      = IX_W'(in_data.pred_class);
  assign in_range = (32'(in_data.true_class) < k32) && (32'(in_data.pred_class) < k32);

  always_comb begin
    unique case (state_r)
      S_IDLE:   rd_addr = {t_x[CLS_W-1:0], p_x[CLS_W-1:0]};
      S_TOT_RD: rd_addr = {i_r, j_r};
      S_ROW_RD: rd_addr = {c_r, j_r};
      S_COL_RD: rd_addr = {j_r, c_r};
      default:  rd_addr = addr_r;
    endcase
  end

  assign cur = vld_r[addr_r] ? ram_rdata : '0;
  assign inc = (cur == {COUNT_BITS{1'b1}}) ? cur : cur + COUNT_BITS'(1);
  assign v   = SUM_W'(cur);

  cmm_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (state_r == S_ACC),
    .waddr (addr_r),
    .wdata (inc),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  always_comb begin
    unique case (sel_r)
      SEL_PREC: begin
        div_num = N_W'(tp_r) << FRAC_BITS;
        div_den = D_W'(col_r);
      end
      SEL_REC: begin
        div_num = N_W'(tp_r) << FRAC_BITS;
        div_den = D_W'(row_r);
      end
      SEL_NPV: begin
        div_num = N_W'(tn_r) << FRAC_BITS;
        div_den = D_W'(dn_r);
      end
      SEL_SPEC: begin
        div_num = N_W'(tn_r) << FRAC_BITS;
        div_den = D_W'(ds_r);
      end
      SEL_MP: begin
        div_num = N_W'(sp_r);
        div_den = kdiv;
      end
      SEL_MR: begin
        div_num = N_W'(sr_r);
        div_den = kdiv;
      end
      SEL_MN: begin
        div_num = N_W'(sn_r);
        div_den = kdiv;
      end
      SEL_MS: begin
        div_num = N_W'(ss_r);
        div_den = kdiv;
      end
      SEL_ACC: begin
        div_num = N_W'(diag_r) << FRAC_BITS;
        div_den = D_W'(total_r);
      end
      default: begin
        div_num = N_W'(fnum_r);
        div_den = D_W'(fden_r);
      end
    endcase
  end

  assign div_go = state_r == S_DIV_GO;

  cmm_div #(
    .N_W (N_W),
    .D_W (D_W),
    .Q_W (Q_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (div_go),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_q)
  );

  assign last_class = c_r == km1;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_range) begin
            state_nxt = S_ACC;
          end else if (in_data.last) begin
            state_nxt = S_TOT_RD;
          end
        end
      end
      S_ACC:    state_nxt = last_r ? S_TOT_RD : S_IDLE;
      S_TOT_RD: state_nxt = S_TOT_AC;
      S_TOT_AC: begin
        if (j_r == km1 && i_r == km1) begin
          state_nxt = S_ROW_RD;
        end else begin
          state_nxt = S_TOT_RD;
        end
      end
      S_ROW_RD: state_nxt = S_ROW_AC;
      S_ROW_AC: state_nxt = S_COL_RD;
      S_COL_RD: state_nxt = S_COL_AC;
      S_COL_AC: state_nxt = (j_r == km1) ? S_CALC1 : S_ROW_RD;
      S_CALC1:  state_nxt = S_CALC2;
      S_CALC2:  state_nxt = S_CALC3;
      S_CALC3:  state_nxt = S_DIV_GO;
      S_DIV_GO: state_nxt = S_DIV_WAIT;
      S_DIV_WAIT: begin
        if (div_done) begin
          unique case (sel_r)
            SEL_SPEC: state_nxt = last_class ? S_DIV_GO : S_ROW_RD;
            SEL_ACC:  state_nxt = S_FMUL1;
            SEL_F:    state_nxt = S_DONE;
            default:  state_nxt = S_DIV_GO;
          endcase
        end
      end
      S_FMUL1:  state_nxt = S_FMUL2;
      S_FMUL2:  state_nxt = S_DIV_GO;
      S_DONE:   state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      class_count_r <= CLASS_COUNT_RST;
      beta_r        <= BETA_SQUARED_RST;
      drop_r        <= '0;
      out_valid     <= 1'b0;
      for (int n = 0; n < DEPTH; n++) begin
        vld_r[n] <= 1'b0;
      end
    end else begin
      state_r   <= state_nxt;
      out_valid <= state_r == S_DONE;
      if (cfg_we) begin
        unique case (cfg_idx)
          CFG_CLASS_COUNT:  class_count_r <= cfg_wdata[4:0];
          CFG_BETA_SQUARED: beta_r        <= cfg_wdata;
          default: ;
        endcase
      end
      if (accept && !in_range && drop_r != 32'hFFFF_FFFF) begin
        drop_r <= drop_r + 32'd1;
      end
      if (state_r == S_ACC) begin
        vld_r[addr_r] <= 1'b1;
      end
      if (state_r == S_DONE) begin
        drop_r <= '0;
        for (int n = 0; n < DEPTH; n++) begin
          vld_r[n] <= 1'b0;
        end
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    addr_r <= rd_addr;
    unique case (state_r)
      S_IDLE: begin
        last_r  <= in_data.last;
        i_r     <= '0;
        j_r     <= '0;
        total_r <= '0;
        diag_r  <= '0;
        sp_r    <= '0;
        sr_r    <= '0;
        sn_r    <= '0;
        ss_r    <= '0;
        row_r   <= '0;
        col_r   <= '0;
        tp_r    <= '0;
      end
      S_TOT_AC: begin
        total_r <= total_r + v;
        if (i_r == j_r) begin
          diag_r <= diag_r + v;
        end
        if (j_r == km1) begin
          j_r <= '0;
          i_r <= i_r + CLS_W'(1);
          // binary rules skip class 0
          c_r <= (k_eff == KW'(2)) ? CLS_W'(1) : '0;
        end else begin
          j_r <= j_r + CLS_W'(1);
        end
      end
      S_ROW_AC: begin
        row_r <= row_r + v;
        if (j_r == c_r) begin
          tp_r <= v;
        end
      end
      S_COL_AC: begin
        col_r <= col_r + v;
        j_r   <= j_r + CLS_W'(1);
      end
      S_CALC1: begin
        fp_r  <= col_r - tp_r;
        fn_r  <= row_r - tp_r;
        t1_r  <= total_r - row_r;
        sel_r <= SEL_PREC;
      end
      S_CALC2: tn_r <= t1_r - fp_r;
      S_CALC3: begin
        dn_r <= tn_r + fn_r;
        ds_r <= tn_r + fp_r;
      end
      S_DIV_WAIT: begin
        if (div_done) begin
          sel_r <= sel_r + 4'd1;
          unique case (sel_r)
            SEL_PREC: sp_r <= sp_r + S_W'(div_q);
            SEL_REC:  sr_r <= sr_r + S_W'(div_q);
            SEL_NPV:  sn_r <= sn_r + S_W'(div_q);
            SEL_SPEC: begin
              ss_r <= ss_r + S_W'(div_q);
              if (!last_class) begin
                c_r   <= c_r + CLS_W'(1);
                j_r   <= '0;
                row_r <= '0;
                col_r <= '0;
                tp_r  <= '0;
              end
            end
            SEL_MP:  prec_r <= div_q;
            SEL_MR:  rec_r  <= div_q;
            SEL_MN:  npv_r  <= div_q;
            SEL_MS:  spec_r <= div_q;
            SEL_ACC: acc_r  <= div_q;
            default: ;
          endcase
        end
      end
      S_FMUL1: begin
        m1_r   <= M1_W'(M1_W'(13'd256 + {1'b0, beta_r}) * M1_W'(prec_r));
        fden_r <= FD_W'(FD_W'(beta_r) * FD_W'(prec_r)) + (FD_W'(rec_r) << 8);
        sel_r  <= SEL_F;
      end
      S_FMUL2: fnum_r <= FN_W'(FN_W'(m1_r) * FN_W'(rec_r));
      default: ;
    endcase
  end

  assign total_x = TX_W'(total_r);

  always_ff @(posedge clk) begin
    if (state_r == S_DONE) begin
      out_data.accuracy       <= acc_r;
      out_data.precision      <= prec_r;
      out_data.recall         <= rec_r;
      out_data.neg_pred_value <= npv_r;
      out_data.specificity    <= spec_r;
      out_data.f_score        <= (div_q > ONE_Q) ? ONE_Q : div_q;
      out_data.total_count    <= (total_x > TX_W'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF
                                                                  : total_x[31:0];
      out_data.dropped_count  <= drop_r;
    end
  end

endmodule
`default_nettype wire

// ===== src/cmm_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none
module cmm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== src/cmm_div.sv =====
// Iterative restoring divider, one quotient bit per cycle.
// Returns floor(num/den) for num < den * 2^Q_W, zero when den is zero.
`default_nettype none
module cmm_div #(
  parameter int N_W = 56,
  parameter int D_W = 40,
  parameter int Q_W = 17
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           go,
  input  wire logic [N_W-1:0] num,
  input  wire logic [D_W-1:0] den,
  output logic                done,
  output logic      [Q_W-1:0] quo
);

  localparam int CNT_W = $clog2(Q_W + 1);

  logic             run_r;
  logic [CNT_W-1:0] cnt_r;
  logic [D_W-1:0]   rem_r;
  logic [D_W-1:0]   den_r;
  logic [Q_W-1:0]   nlo_r;
  logic [Q_W-1:0]   quo_r;
  logic             done_r;
  logic [D_W:0]     rs;
  logic             qbit;

  assign rs   = {rem_r, nlo_r[Q_W-1]};
  assign qbit = rs >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        if (den == '0) begin
          quo_r  <= '0;
          done_r <= 1'b1;
        end else begin
          run_r <= 1'b1;
          cnt_r <= CNT_W'(Q_W);
          quo_r <= '0;
        end
        // high part is already below den by the precondition
        rem_r <= D_W'(num >> Q_W);
        nlo_r <= num[Q_W-1:0];
        den_r <= den;
      end else if (run_r) begin
        rem_r <= qbit ? D_W'(rs - {1'b0, den_r}) : rs[D_W-1:0];
        quo_r <= {quo_r[Q_W-2:0], qbit};
        nlo_r <= nlo_r << 1;
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule
`default_nettype wire
